// File: rtl/core/r1cs_pkg.sv
package r1cs_pkg;

   localparam int MAX_NODES     = 256;
   localparam int FRACTION_BITS = 32;
   localparam int NODE_BITS     = 8;
   localparam int SLOT_BITS     = 9;
   localparam int STORE_DEPTH   = MAX_NODES + 1;

   localparam logic [63:0] Q_ONE   = 64'(1) << FRACTION_BITS;
   localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;
   localparam logic [127:0] ROUND_HALF =
      (FRACTION_BITS > 0) ? (128'(1) << (FRACTION_BITS - 1)) : 128'(0);

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_UNMAPPED = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_SAT      = 2'd3;

   typedef enum logic [1:0] {
      OP_VAR   = 2'd0,
      OP_CONST = 2'd1,
      OP_ADD   = 2'd2,
      OP_MUL   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RESTART,
      S_MAP,
      S_CHECK,
      S_EXEC,
      S_MUL,
      S_RND
   } state_type;

   typedef struct packed {
      logic [1:0]         node_op;
      logic [7:0]         left_node;
      logic [7:0]         right_node;
      logic signed [63:0] coefficient;
      logic               first_node;
   } req_type;

   typedef struct packed {
      logic [8:0]         witness_slot;
      logic [8:0]         a_slot;
      logic signed [63:0] a_weight;
      logic [8:0]         b_first_slot;
      logic [1:0]         b_first_weight;
      logic [8:0]         b_second_slot;
      logic               b_second_used;
      logic signed [63:0] node_value;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      op_type             op;
      logic [7:0]         left_node;
      logic [7:0]         right_node;
      logic [63:0]        coefficient;
      logic               first_node;
      logic [8:0]         idx;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage

// File: rtl/core/r1cs_ram.sv
module r1cs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 257
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr0,
   input  logic [$clog2(DEPTH)-1:0] raddr1,
   output logic [WIDTH-1:0]         rdata0,
   output logic [WIDTH-1:0]         rdata1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata0 <= mem_ff[raddr0];
      rdata1 <= mem_ff[raddr1];
   end

endmodule

// File: rtl/core/r1cs_front.sv
module r1cs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  r1cs_pkg::req_type   req_data,
   input  logic                pop,
   output r1cs_pkg::head_type  head
);

   r1cs_pkg::item_type fifo_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [8:0] node_count_ff, node_count_in;
   logic       accept, push;
   r1cs_pkg::item_type item;

   assign req_stall = (cnt_ff == 2'd2);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      item.op          = r1cs_pkg::op_type'(req_data.node_op);
      item.left_node   = req_data.left_node;
      item.right_node  = req_data.right_node;
      item.coefficient = req_data.coefficient;
      item.first_node  = req_data.first_node;
      item.idx         = req_data.first_node ? 9'd0 : node_count_ff;
      // non-first variables leave no mark on the back end
      push = accept && (req_data.first_node || (item.op != r1cs_pkg::OP_VAR));
      node_count_in = node_count_ff;
      if (accept) begin
         node_count_in = (item.idx < 9'(r1cs_pkg::MAX_NODES)) ? item.idx + 9'd1 : item.idx;
      end
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         cnt_ff        <= 2'd0;
         node_count_ff <= 9'd0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         cnt_ff        <= cnt_in;
         node_count_ff <= node_count_in;
      end
      if (push) begin
         fifo_ff[wr_ptr_ff] <= item;
      end
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = fifo_ff[rd_ptr_ff];

endmodule

// File: rtl/core/r1cs_back.sv
module r1cs_back (
   input  logic               clock,
   input  logic               reset,
   input  r1cs_pkg::head_type head,
   output logic               pop,
   input  logic [63:0]        input_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output r1cs_pkg::rsp_type  rsp_data
);

   r1cs_pkg::state_type state_ff, state_in;
   r1cs_pkg::item_type  cur_ff, cur_in;
   r1cs_pkg::rsp_type   rsp_ff, res;
   logic [8:0]   next_slot_ff, next_slot_in;
   logic [255:0] valid_ff, valid_in;
   logic [8:0]   ls_ff, ls_in, rs_ff, rs_in;
   logic [63:0]  ma_ff, ma_in, mb_ff, mb_in, pp_ff, pp_in;
   logic         neg_ff, neg_in;
   logic [127:0] acc_ff, acc_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         rsp_valid_ff, load, commit, blocked;

   logic         map_we, wit_we;
   logic [7:0]   map_waddr;
   logic [8:0]   map_wdata, map_rd0, map_rd1, wit_waddr;
   logic [63:0]  wit_wdata, wit_rd0, wit_rd1;

   logic [63:0]  sum, val;
   logic [127:0] rounded, shifted;
   logic [1:0]   j;
   logic [31:0]  mul_a, mul_b;
   logic         sat;

   r1cs_ram #(.WIDTH(r1cs_pkg::SLOT_BITS), .DEPTH(r1cs_pkg::MAX_NODES)) u_map (
      .clock (clock),
      .we    (map_we),
      .waddr (map_waddr),
      .wdata (map_wdata),
      .raddr0(cur_ff.left_node),
      .raddr1(cur_ff.right_node),
      .rdata0(map_rd0),
      .rdata1(map_rd1)
   );

   r1cs_ram #(.WIDTH(64), .DEPTH(r1cs_pkg::STORE_DEPTH)) u_store (
      .clock (clock),
      .we    (wit_we),
      .waddr (wit_waddr),
      .wdata (wit_wdata),
      .raddr0(map_rd0),
      .raddr1(map_rd1),
      .rdata0(wit_rd0),
      .rdata1(wit_rd1)
   );

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      next_slot_in = next_slot_ff;
      valid_in     = valid_ff;
      ls_in        = ls_ff;
      rs_in        = rs_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      neg_in       = neg_ff;
      pp_in        = pp_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      pop          = 1'b0;
      load         = 1'b0;
      commit       = 1'b0;
      blocked      = rsp_valid_ff && rsp_stall;
      map_we       = 1'b0;
      map_waddr    = cur_ff.idx[7:0];
      map_wdata    = next_slot_ff;
      wit_we       = 1'b0;
      wit_waddr    = next_slot_ff;
      wit_wdata    = 64'd0;
      res          = '0;
      res.b_first_weight = 2'd1;
      val          = 64'd0;
      sat          = 1'b0;
      sum          = wit_rd0 + wit_rd1;
      rounded      = acc_ff + r1cs_pkg::ROUND_HALF;
      shifted      = rounded >> r1cs_pkg::FRACTION_BITS;
      j            = cnt_ff[1:0] - 2'd1;
      mul_a        = cnt_ff[0] ? ma_ff[63:32] : ma_ff[31:0];
      mul_b        = cnt_ff[1] ? mb_ff[63:32] : mb_ff[31:0];

      unique case (state_ff)
         r1cs_pkg::S_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               cur_in   = head.item;
               state_in = head.item.first_node ? r1cs_pkg::S_RESTART : r1cs_pkg::S_MAP;
            end
         end
         r1cs_pkg::S_RESTART: begin
            map_we       = 1'b1;
            map_waddr    = 8'd0;
            map_wdata    = 9'd1;
            wit_we       = 1'b1;
            wit_waddr    = 9'd1;
            wit_wdata    = input_value;
            valid_in     = 256'd1;
            next_slot_in = 9'd2;
            state_in = (cur_ff.op == r1cs_pkg::OP_VAR) ? r1cs_pkg::S_IDLE : r1cs_pkg::S_MAP;
         end
         r1cs_pkg::S_MAP: begin
            state_in = r1cs_pkg::S_CHECK;
         end
         r1cs_pkg::S_CHECK: begin
            ls_in = map_rd0;
            rs_in = map_rd1;
            // hold while the output register still waits
            if (blocked) begin
               state_in = r1cs_pkg::S_CHECK;
            end else if (cur_ff.idx >= 9'(r1cs_pkg::MAX_NODES)
                || next_slot_ff > 9'(r1cs_pkg::MAX_NODES)) begin
               res        = '0;
               res.status = r1cs_pkg::ST_FULL;
               load       = 1'b1;
               state_in   = r1cs_pkg::S_IDLE;
            end else if (cur_ff.op == r1cs_pkg::OP_CONST) begin
               val          = cur_ff.coefficient;
               res.a_weight = cur_ff.coefficient;
               commit       = 1'b1;
               state_in     = r1cs_pkg::S_IDLE;
            end else if (!valid_ff[cur_ff.left_node] || !valid_ff[cur_ff.right_node]) begin
               res        = '0;
               res.status = r1cs_pkg::ST_UNMAPPED;
               load       = 1'b1;
               state_in   = r1cs_pkg::S_IDLE;
            end else begin
               state_in = r1cs_pkg::S_EXEC;
            end
         end
         r1cs_pkg::S_EXEC: begin
            if (cur_ff.op == r1cs_pkg::OP_ADD) begin
               if (!blocked) begin
                  val = sum;
                  if (wit_rd0[63] == wit_rd1[63] && sum[63] != wit_rd0[63]) begin
                     sat = 1'b1;
                     val = wit_rd0[63] ? r1cs_pkg::MIN_NEG : r1cs_pkg::MAX_POS;
                  end
                  res.a_weight     = r1cs_pkg::Q_ONE;
                  res.b_first_slot = ls_ff;
                  if (ls_ff == rs_ff) begin
                     res.b_first_weight = 2'd2;
                  end else begin
                     res.b_second_slot = rs_ff;
                     res.b_second_used = 1'b1;
                  end
                  commit   = 1'b1;
                  state_in = r1cs_pkg::S_IDLE;
               end
            end else begin
               neg_in   = wit_rd0[63] ^ wit_rd1[63];
               ma_in    = wit_rd0[63] ? (~wit_rd0 + 64'd1) : wit_rd0;
               mb_in    = wit_rd1[63] ? (~wit_rd1 + 64'd1) : wit_rd1;
               acc_in   = 128'd0;
               cnt_in   = 3'd0;
               state_in = r1cs_pkg::S_MUL;
            end
         end
         r1cs_pkg::S_MUL: begin
            // one 32x32 partial product a cycle, added in the cycle after
            if (cnt_ff != 3'd4) begin
               pp_in = 64'(mul_a) * 64'(mul_b);
            end
            if (cnt_ff != 3'd0) begin
               acc_in = acc_ff + ({64'd0, pp_ff} << (7'(j[0]) * 7'd32 + 7'(j[1]) * 7'd32));
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               state_in = r1cs_pkg::S_RND;
            end
         end
         r1cs_pkg::S_RND: begin
            if (!blocked) begin
               if (!neg_ff) begin
                  if (shifted[127:64] != 64'd0 || shifted[63]) begin
                     sat = 1'b1;
                     val = r1cs_pkg::MAX_POS;
                  end else begin
                     val = shifted[63:0];
                  end
               end else if (shifted[127:64] != 64'd0 || shifted[63:0] > r1cs_pkg::MIN_NEG) begin
                  sat = 1'b1;
                  val = r1cs_pkg::MIN_NEG;
               end else begin
                  val = ~shifted[63:0] + 64'd1;
               end
               res.a_slot       = ls_ff;
               res.a_weight     = r1cs_pkg::Q_ONE;
               res.b_first_slot = rs_ff;
               commit           = 1'b1;
               state_in         = r1cs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = r1cs_pkg::S_IDLE;
         end
      endcase

      if (commit) begin
         map_we       = 1'b1;
         wit_we       = 1'b1;
         wit_wdata    = val;
         valid_in[cur_ff.idx[7:0]] = 1'b1;
         next_slot_in = next_slot_ff + 9'd1;
         res.witness_slot = next_slot_ff;
         res.node_value   = val;
         res.status       = sat ? r1cs_pkg::ST_SAT : r1cs_pkg::ST_OK;
         load             = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= r1cs_pkg::S_IDLE;
         next_slot_ff <= 9'd2;
         valid_ff     <= 256'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_slot_ff <= next_slot_in;
         valid_ff     <= valid_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      cur_ff <= cur_in;
      ls_ff  <= ls_in;
      rs_ff  <= rs_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      neg_ff <= neg_in;
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_commit_loads: assert property (@(posedge clock) disable iff (reset)
      map_we && state_ff != r1cs_pkg::S_RESTART |-> load)
      else $error("map written without a transaction");

   a_restart_maps_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == r1cs_pkg::S_RESTART |=> valid_ff[0] && next_slot_ff == 9'd2)
      else $error("restart did not map node zero");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !rsp_valid_ff || !rsp_stall)
      else $error("result dropped while output stalled");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      wit_we |-> wit_waddr <= 9'(r1cs_pkg::MAX_NODES))
      else $error("witness write beyond store");

endmodule

// File: rtl/core/r1cs_witness_generator_top.sv
// R1CS witness generator. Nodes enter on the req_ channel and are queued; one
// constraint transaction per constant, addition or multiplication node leaves on
// the rsp_ channel (variable nodes give none, and only a first variable enters
// the two-entry queue). The queue takes a new node each cycle while it has room.
// The execution engine handles one node at a time: after it dequeues a node, the
// node-map read, the dependent witness-store read and, for products, four 32x32
// partial products done on one multiplier, a final accumulate and a rounding step
// come before its result is loaded. A constant, an unmapped node and a node that
// finds the store full load theirs after the node-map read. A first node also
// passes through a restart step that reloads the node map and writes input_value
// to slot 1. While an earlier result waits on rsp_stall the engine holds before
// loading the next one.
// input_value sits at byte address 0 of the APB port.
module r1cs_witness_generator_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  r1cs_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output r1cs_pkg::rsp_type  rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [63:0]        pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);

   logic [63:0]        input_value_ff;
   logic               pop;
   r1cs_pkg::head_type head;

   assign pready = 1'b1;
   assign prdata = (paddr == 4'd0) ? input_value_ff : 64'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_value_ff <= 64'd0;
      end else if (psel && penable && pwrite && paddr == 4'd0) begin
         input_value_ff <= pwdata;
      end
   end

   r1cs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .pop      (pop),
      .head     (head)
   );

   r1cs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .input_value(input_value_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// File: tb/tb_r1cs_witness_generator_top.sv
module tb_r1cs_witness_generator_top;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   r1cs_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   r1cs_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic pready;

   localparam logic [3:0] ADDR_INPUT_VALUE = 4'd0;

   r1cs_witness_generator_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic [63:0] cur_input;
   logic        map_ok [r1cs_pkg::MAX_NODES];
   logic [8:0]  map_slot [r1cs_pkg::MAX_NODES];
   logic [63:0] wstore [r1cs_pkg::STORE_DEPTH];
   int unsigned next_slot;
   int unsigned node_count;

   r1cs_pkg::req_type pending_nodes[$];
   r1cs_pkg::rsp_type expected_rsps[$];
   int unsigned mismatches = 0;
   bit no_idle = 1'b0;
   bit hold_rsp = 1'b0;
   int unsigned accepted = 0;

   function automatic void queue_node(input r1cs_pkg::req_type n);
      pending_nodes = {pending_nodes, n};
   endfunction

   function automatic void expect_rsp(input r1cs_pkg::rsp_type r);
      expected_rsps = {expected_rsps, r};
   endfunction

   function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b,
                                           inout bit sat);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         sat = 1'b1;
         return a[63] ? r1cs_pkg::MIN_NEG : r1cs_pkg::MAX_POS;
      end
      return s;
   endfunction

   function automatic logic [63:0] mul_sat(input logic [63:0] a, input logic [63:0] b,
                                           inout bit sat);
      logic neg;
      logic [127:0] ma, mb, p;
      neg = a[63] ^ b[63];
      ma = {64'd0, a[63] ? -a : a};
      mb = {64'd0, b[63] ? -b : b};
      p = ma * mb;
      p = (p + r1cs_pkg::ROUND_HALF) >> r1cs_pkg::FRACTION_BITS;
      if (!neg) begin
         if (p > {64'd0, r1cs_pkg::MAX_POS}) begin
            sat = 1'b1;
            return r1cs_pkg::MAX_POS;
         end
         return p[63:0];
      end
      if (p > {64'd0, r1cs_pkg::MIN_NEG}) begin
         sat = 1'b1;
         return r1cs_pkg::MIN_NEG;
      end
      return -p[63:0];
   endfunction

   task automatic predict_constraint(input r1cs_pkg::req_type n);
      r1cs_pkg::rsp_type r;
      int unsigned idx;
      logic [8:0] ls, rs;
      bit sat;
      r = '0;
      sat = 1'b0;
      if (n.first_node) begin
         for (int i = 0; i < r1cs_pkg::MAX_NODES; i++) map_ok[i] = 1'b0;
         map_ok[0] = 1'b1;
         map_slot[0] = 9'd1;
         wstore[1] = cur_input;
         next_slot = 2;
         node_count = 0;
      end
      idx = node_count;
      if (node_count < r1cs_pkg::MAX_NODES) node_count++;
      if (n.node_op == r1cs_pkg::OP_VAR) return;
      if (idx >= r1cs_pkg::MAX_NODES || next_slot > r1cs_pkg::MAX_NODES) begin
         r.status = r1cs_pkg::ST_FULL;
         expect_rsp(r);
         return;
      end
      if (n.node_op != r1cs_pkg::OP_CONST) begin
         if (!map_ok[n.left_node] || !map_ok[n.right_node]) begin
            r.status = r1cs_pkg::ST_UNMAPPED;
            expect_rsp(r);
            return;
         end
         ls = map_slot[n.left_node];
         rs = map_slot[n.right_node];
      end
      r.witness_slot = next_slot[8:0];
      r.b_first_weight = 2'd1;
      case (n.node_op)
         r1cs_pkg::OP_CONST: begin
            r.node_value = n.coefficient;
            r.a_weight = n.coefficient;
         end
         r1cs_pkg::OP_ADD: begin
            r.node_value = add_sat(wstore[ls], wstore[rs], sat);
            r.a_weight = r1cs_pkg::Q_ONE;
            r.b_first_slot = ls;
            if (ls == rs) r.b_first_weight = 2'd2;
            else begin
               r.b_second_slot = rs;
               r.b_second_used = 1'b1;
            end
         end
         default: begin
            r.node_value = mul_sat(wstore[ls], wstore[rs], sat);
            r.a_slot = ls;
            r.a_weight = r1cs_pkg::Q_ONE;
            r.b_first_slot = rs;
         end
      endcase
      wstore[next_slot] = r.node_value;
      map_ok[idx] = 1'b1;
      map_slot[idx] = next_slot[8:0];
      next_slot++;
      r.status = sat ? r1cs_pkg::ST_SAT : r1cs_pkg::ST_OK;
      expect_rsp(r);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_constraint(req_data);
            accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_nodes.size() > 0 && (no_idle || $urandom_range(99) >= 32)) begin
               req_data <= pending_nodes.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction %h", rsp_data);
            end else begin
               r1cs_pkg::rsp_type e;
               e = expected_rsps.pop_front();
               if (e !== rsp_data) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp slot=%0d a=%0d/%h b1=%0d/%0d b2=%0d/%0d val=%h st=%0d",
                        e.witness_slot, e.a_slot, e.a_weight, e.b_first_slot,
                        e.b_first_weight, e.b_second_slot, e.b_second_used,
                        e.node_value, e.status, "\n          act slot=%0d a=%0d/%h",
                        rsp_data.witness_slot, rsp_data.a_slot, rsp_data.a_weight,
                        " b1=%0d/%0d b2=%0d/%0d val=%h st=%0d",
                        rsp_data.b_first_slot, rsp_data.b_first_weight,
                        rsp_data.b_second_slot, rsp_data.b_second_used,
                        rsp_data.node_value, rsp_data.status);
               end
            end
         end
         rsp_stall <= hold_rsp || (!no_idle && $urandom_range(99) < 32);
      end
   end

   task automatic csr_write(input logic [63:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= ADDR_INPUT_VALUE;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      cur_input = value;
   endtask

   task automatic drain();
      while (pending_nodes.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [63:0] rand_q(input int mode);
      case (mode)
         0: return {$urandom, $urandom};
         1: return {{32{1'($urandom_range(1))}}, $urandom};
         2: return 64'(signed'($urandom_range(16) - 8)) << 32;
         3: return $urandom_range(1) ? r1cs_pkg::MAX_POS : r1cs_pkg::MIN_NEG;
         default: return {{30{1'b0}}, 2'($urandom), $urandom};
      endcase
   endfunction

   function automatic r1cs_pkg::req_type mk(input r1cs_pkg::op_type op, input int l,
                                            input int r, input logic [63:0] c,
                                            input bit f);
      r1cs_pkg::req_type n;
      n.node_op = op;
      n.left_node = l[7:0];
      n.right_node = r[7:0];
      n.coefficient = c;
      n.first_node = f;
      return n;
   endfunction

   // one well-formed circuit with random content, plus occasional noise
   task automatic queue_circuit(input int len);
      int cnt;
      r1cs_pkg::op_type op;
      cnt = 1;
      queue_node(mk(r1cs_pkg::OP_VAR, 0, 0, rand_q(0), 1'b1));
      for (int i = 1; i < len; i++) begin
         op = r1cs_pkg::op_type'($urandom_range(3));
         if ($urandom_range(9) == 0)
            queue_node(mk(op, $urandom_range(255), $urandom_range(255),
                          rand_q(0), 1'b0));
         else
            queue_node(mk(op, $urandom_range(cnt - 1),
                          $urandom_range(cnt - 1),
                          rand_q($urandom_range(4)), 1'b0));
         cnt++;
      end
   endtask

   initial begin
      cur_input = '0;
      for (int i = 0; i < r1cs_pkg::MAX_NODES; i++) begin
         map_ok[i] = 1'b0;
         map_slot[i] = '0;
      end
      for (int i = 0; i < r1cs_pkg::STORE_DEPTH; i++) wstore[i] = '0;
      next_slot = 2;
      node_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      csr_write(64'h0000_0002_8000_0000);
      // directed: extremes, every kind, self-add, self-reference, unmapped operands
      queue_node(mk(r1cs_pkg::OP_VAR, 0, 0, '0, 1'b1));
      queue_node(mk(r1cs_pkg::OP_CONST, 255, 255, r1cs_pkg::MAX_POS, 1'b0));
      queue_node(mk(r1cs_pkg::OP_CONST, 0, 0, r1cs_pkg::MIN_NEG, 1'b0));
      queue_node(mk(r1cs_pkg::OP_ADD, 0, 0, '0, 1'b0));
      queue_node(mk(r1cs_pkg::OP_ADD, 1, 2, '0, 1'b0));
      queue_node(mk(r1cs_pkg::OP_ADD, 1, 1, '0, 1'b0));
      queue_node(mk(r1cs_pkg::OP_MUL, 0, 3, '0, 1'b0));
      queue_node(mk(r1cs_pkg::OP_MUL, 1, 1, '0, 1'b0));
      queue_node(mk(r1cs_pkg::OP_MUL, 2, 2, '0, 1'b0));
      queue_node(mk(r1cs_pkg::OP_MUL, 9, 0, '0, 1'b0));
      queue_node(mk(r1cs_pkg::OP_ADD, 0, 255, '0, 1'b0));
      queue_node(mk(r1cs_pkg::OP_VAR, 0, 0, '0, 1'b0));
      queue_node(mk(r1cs_pkg::OP_ADD, 12, 0, '0, 1'b0));
      queue_node(mk(r1cs_pkg::OP_MUL, 3, 1, '0, 1'b0));
      queue_node(mk(r1cs_pkg::OP_CONST, 0, 0, 64'hFFFF_FFFF_8000_0000, 1'b0));
      queue_node(mk(r1cs_pkg::OP_MUL, 0, 15, '0, 1'b0));
      queue_node(mk(r1cs_pkg::OP_MUL, 0, 0, '0, 1'b1));
      queue_node(mk(r1cs_pkg::OP_ADD, 0, 0, '0, 1'b0));
      queue_node(mk(r1cs_pkg::OP_CONST, 0, 0, 64'h1, 1'b1));
      drain();

      csr_write(r1cs_pkg::MAX_POS);
      queue_node(mk(r1cs_pkg::OP_ADD, 0, 0, '0, 1'b1));
      queue_node(mk(r1cs_pkg::OP_MUL, 0, 0, '0, 1'b0));
      drain();
      csr_write(r1cs_pkg::MIN_NEG);
      queue_node(mk(r1cs_pkg::OP_ADD, 0, 0, '0, 1'b1));
      queue_node(mk(r1cs_pkg::OP_MUL, 0, 0, '0, 1'b0));
      drain();

      // overfill one circuit so the store-full path is hit
      csr_write(rand_q(1));
      queue_circuit(262);
      drain();

      // backpressure: hold the result side while nodes pile up
      hold_rsp = 1'b1;
      queue_circuit(60);
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         csr_write(rand_q(ph % 4));
         no_idle = (ph == 3);
         for (int c = 0; c < 10; c++) queue_circuit($urandom_range(4, 40));
         drain();
      end
      no_idle = 1'b0;

      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: files.f
rtl/core/r1cs_pkg.sv
rtl/core/r1cs_ram.sv
rtl/core/r1cs_front.sv
rtl/core/r1cs_back.sv
rtl/core/r1cs_witness_generator_top.sv
tb/tb_r1cs_witness_generator_top.sv
